@@ sv/cbnp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbnp_pkg
// Types, character constants and helpers shared by the custom base number
// parser modules.
// ----------------------------------------------------------------------------
package cbnp_pkg;

   localparam int unsigned MAX_DIGITS = 16;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      PH_SPACE = 2'd0,
      PH_SIGN  = 2'd1,
      PH_DIGIT = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
   } match_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

endpackage

@@ sv/cbnp_digit_match.sv @@
// ----------------------------------------------------------------------------
// cbnp_digit_match
// Parallel lookup of a byte in the digit set and validity check of the set.
// ----------------------------------------------------------------------------
module cbnp_digit_match (
   input  logic [cbnp_pkg::CHAR_W-1:0]     character,
   input  logic [cbnp_pkg::CSR_DATA_W-1:0] digits_low,
   input  logic [cbnp_pkg::CSR_DATA_W-1:0] digits_high,
   input  logic [cbnp_pkg::LEN_W-1:0]      base_length,
   output cbnp_pkg::match_type             match,
   output logic                            set_invalid
);

   logic [cbnp_pkg::CHAR_W-1:0] digit_chars [cbnp_pkg::MAX_DIGITS];
   logic [cbnp_pkg::LEN_W-1:0]  used_len;
   logic                        bad_char;
   logic                        dup_char;

   always_comb begin
      for (int k = 0; k < cbnp_pkg::MAX_DIGITS; k++) begin
         if (k < 8) begin
            digit_chars[k] = digits_low[8*(k%8) +: 8];
         end else begin
            digit_chars[k] = digits_high[8*(k%8) +: 8];
         end
      end
   end

   assign used_len = (base_length > cbnp_pkg::LEN_W'(cbnp_pkg::MAX_DIGITS)) ?
                     cbnp_pkg::LEN_W'(cbnp_pkg::MAX_DIGITS) : base_length;

   always_comb begin
      match = '0;
      for (int k = cbnp_pkg::MAX_DIGITS - 1; k >= 0; k--) begin
         if ((cbnp_pkg::LEN_W'(k) < used_len) && (digit_chars[k] == character) &&
             (character != cbnp_pkg::CHAR_NUL)) begin
            match.hit   = 1'b1;
            match.index = cbnp_pkg::IDX_W'(k);
         end
      end
   end

   always_comb begin
      bad_char = 1'b0;
      dup_char = 1'b0;
      for (int i = 0; i < cbnp_pkg::MAX_DIGITS; i++) begin
         if (cbnp_pkg::LEN_W'(i) < used_len) begin
            if ((digit_chars[i] == cbnp_pkg::CHAR_NUL) ||
                (digit_chars[i] == cbnp_pkg::CHAR_MINUS) ||
                (digit_chars[i] == cbnp_pkg::CHAR_PLUS) ||
                cbnp_pkg::is_space(digit_chars[i])) begin
               bad_char = 1'b1;
            end
            for (int j = i + 1; j < cbnp_pkg::MAX_DIGITS; j++) begin
               if ((cbnp_pkg::LEN_W'(j) < used_len) && (digit_chars[j] == digit_chars[i])) begin
                  dup_char = 1'b1;
               end
            end
         end
      end
   end

   assign set_invalid = (base_length < cbnp_pkg::LEN_W'(2)) ||
                        (base_length > cbnp_pkg::LEN_W'(cbnp_pkg::MAX_DIGITS)) ||
                        bad_char || dup_char;

endmodule

@@ sv/cbnp_parse_core.sv @@
// ----------------------------------------------------------------------------
// cbnp_parse_core
// Parse state of one string: phase, sign, accumulated magnitude and wrap flag.
// ----------------------------------------------------------------------------
module cbnp_parse_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [cbnp_pkg::CHAR_W-1:0]      character,
   input  logic                             last,
   input  cbnp_pkg::match_type              match,
   input  logic [cbnp_pkg::LEN_W-1:0]       base_length,
   input  logic                             set_invalid,
   output logic signed [cbnp_pkg::VALUE_W-1:0] res_value,
   output logic                             res_overflow
);

   localparam int unsigned PROD_W = cbnp_pkg::VALUE_W + cbnp_pkg::LEN_W;

   cbnp_pkg::phase_type           phase_ff, phase_in;
   logic                          negative_ff, negative_in;
   logic [cbnp_pkg::VALUE_W-1:0]  acc_ff, acc_in;
   logic                          wrapped_ff, wrapped_in;
   logic                          at_sign;
   logic                          at_digit;
   logic [PROD_W-1:0]             product;

   assign at_sign  = (phase_ff == cbnp_pkg::PH_SIGN) ||
                     ((phase_ff == cbnp_pkg::PH_SPACE) && !cbnp_pkg::is_space(character));
   assign at_digit = (phase_ff == cbnp_pkg::PH_DIGIT) ||
                     (at_sign && (character != cbnp_pkg::CHAR_MINUS) &&
                      (character != cbnp_pkg::CHAR_PLUS));

   always_comb begin
      phase_in = phase_ff;
      if (at_digit) begin
         phase_in = match.hit ? cbnp_pkg::PH_DIGIT : cbnp_pkg::PH_DONE;
      end else if (at_sign) begin
         phase_in = cbnp_pkg::PH_SIGN;
      end
   end

   assign product = PROD_W'(acc_ff) * PROD_W'(base_length) + PROD_W'(match.index);

   always_comb begin
      negative_in = negative_ff ^ (at_sign && (character == cbnp_pkg::CHAR_MINUS));
      acc_in      = acc_ff;
      wrapped_in  = wrapped_ff;
      if (at_digit && match.hit) begin
         acc_in     = product[cbnp_pkg::VALUE_W-1:0];
         wrapped_in = wrapped_ff | (|product[PROD_W-1:cbnp_pkg::VALUE_W]);
      end
   end

   always_comb begin
      if (set_invalid) begin
         res_value    = '0;
         res_overflow = 1'b0;
      end else begin
         res_value    = negative_in ? -$signed(acc_in) : $signed(acc_in);
         res_overflow = wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cbnp_pkg::PH_SPACE;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
         wrapped_ff  <= 1'b0;
      end else if (step) begin
         if (last) begin
            phase_ff    <= cbnp_pkg::PH_SPACE;
            negative_ff <= 1'b0;
            acc_ff      <= '0;
            wrapped_ff  <= 1'b0;
         end else begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            acc_ff      <= acc_in;
            wrapped_ff  <= wrapped_in;
         end
      end
   end

endmodule

@@ sv/custom_base_number_parser.sv @@
// ----------------------------------------------------------------------------
// custom_base_number_parser
// Signed integer parser over a configurable digit set, one byte per item.
// ----------------------------------------------------------------------------
// Bytes of a string enter one item per cycle. Each item is registered, then
// parsed against the digit set; the digit lookup, the multiply-accumulate of
// the 32-bit magnitude and the sign logic sit between the input register and
// the result register. An item marked last yields one result in the result
// register, and the parser restarts with the next item. The input stalls
// only while a last item waits behind a result that the consumer has not
// taken. Digit set registers are written through the csr port, which is
// always ready; the user must write them only while no string is being
// parsed, as the block itself does not enforce this.
module custom_base_number_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cbnp_pkg::CHAR_W-1:0]           req_character,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cbnp_pkg::VALUE_W-1:0]   rsp_value,
   output logic                                  rsp_base_invalid,
   output logic                                  rsp_overflow,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cbnp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cbnp_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [cbnp_pkg::CSR_DATA_W-1:0]     digits_low_ff;
   logic [cbnp_pkg::CSR_DATA_W-1:0]     digits_high_ff;
   logic [cbnp_pkg::LEN_W-1:0]          base_length_ff;
   logic                                s1_valid_ff, s1_valid_in;
   logic [cbnp_pkg::CHAR_W-1:0]         s1_char_ff;
   logic                                s1_last_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [cbnp_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                                rsp_invalid_ff;
   logic                                rsp_overflow_ff;
   logic                                out_free;
   logic                                s1_go;
   logic                                s1_emit;
   logic                                req_take;
   cbnp_pkg::match_type                 match;
   logic                                set_invalid;
   logic signed [cbnp_pkg::VALUE_W-1:0] res_value;
   logic                                res_overflow;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
         base_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbnp_pkg::CSR_DIGITS_LOW:  digits_low_ff  <= csr_data;
            cbnp_pkg::CSR_DIGITS_HIGH: digits_high_ff <= csr_data;
            cbnp_pkg::CSR_BASE_LENGTH: base_length_ff <= csr_data[cbnp_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign s1_emit   = s1_go && s1_last_ff;
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_character;
         s1_last_ff <= req_last;
      end
      if (s1_emit) begin
         rsp_value_ff    <= res_value;
         rsp_invalid_ff  <= set_invalid;
         rsp_overflow_ff <= res_overflow;
      end
   end

   cbnp_digit_match u_digit_match (
      .character   (s1_char_ff),
      .digits_low  (digits_low_ff),
      .digits_high (digits_high_ff),
      .base_length (base_length_ff),
      .match       (match),
      .set_invalid (set_invalid)
   );

   cbnp_parse_core u_parse_core (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .character    (s1_char_ff),
      .last         (s1_last_ff),
      .match        (match),
      .base_length  (base_length_ff),
      .set_invalid  (set_invalid),
      .res_value    (res_value),
      .res_overflow (res_overflow)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_base_invalid = rsp_invalid_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

@@ sv/cbnp_checker.sv @@
// ----------------------------------------------------------------------------
// cbnp_checker
// Port-level checks of the custom base number parser, bound to the top level.
// ----------------------------------------------------------------------------
module cbnp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_last,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [cbnp_pkg::VALUE_W-1:0] rsp_value,
   input logic                                rsp_base_invalid,
   input logic                                rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
                                 $stable(rsp_overflow) && $stable(rsp_base_invalid))
      else $error("stalled result item changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_base_invalid |-> (rsp_value == '0) && !rsp_overflow)
      else $error("invalid digit set gave a nonzero result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last, 2))
      else $error("result item without a last input item");

endmodule

bind custom_base_number_parser cbnp_checker u_cbnp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_value        (rsp_value),
   .rsp_base_invalid (rsp_base_invalid),
   .rsp_overflow     (rsp_overflow)
);
